/* rtl/core/mcpi_pkg.sv */
// shared types and constants of the motor current pi drive core
package mcpi_pkg;

	typedef enum logic [1:0] {
		OP_RAW     = 2'd0,
		OP_CURRENT = 2'd1,
		OP_TORQUE  = 2'd2,
		OP_RESET   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TORQ_SCALE,
		ST_CUR,
		ST_PMUL,
		ST_IMUL_LO,
		ST_IMUL_HI,
		ST_ISAT,
		ST_SUM,
		ST_CLAMP,
		ST_DTMUL,
		ST_INTEG,
		ST_DB_CHK,
		ST_DB_M2,
		ST_DB_M3,
		ST_DB_CLAMP,
		ST_DIV,
		ST_DRIVE
	} st_t;

	localparam logic [2:0] CFG_DUTY_LIMIT    = 3'd0;
	localparam logic [2:0] CFG_DEADBAND      = 3'd1;
	localparam logic [2:0] CFG_CURRENT_LIMIT = 3'd2;
	localparam logic [2:0] CFG_PROP_GAIN     = 3'd3;
	localparam logic [2:0] CFG_INTEG_GAIN    = 3'd4;
	localparam logic [2:0] CFG_INV_TORQUE    = 3'd5;
	localparam logic [2:0] CFG_TORQUE_EPS    = 3'd6;
	localparam logic [2:0] CFG_RAW_EPS       = 3'd7;

	localparam logic [14:0] DUTY_LIMIT_RST = 15'h7FFF;
	localparam logic [14:0] CUR_LIMIT_RST  = 15'h7FFF;
	localparam logic [31:0] INV_TORQUE_RST = 32'h0001_0000;
	localparam logic [31:0] UNITY_Q16      = 32'h0001_0000;
	localparam logic [15:0] DT_DEFAULT     = 16'd5000;

	// product magnitude cap, 2^61
	localparam logic [61:0] PROD_CAP = 62'h2000_0000_0000_0000;

	// last divider count (15 quotient bits), quotient does not exceed the duty limit
	localparam logic [3:0] DIV_LAST = 4'd14;

endpackage

/* rtl/core/motor_current_pi_drive_core.sv */
// motor current pi drive core: raw, current and torque duty with pi loop and deadband
//
//  channel   signals                                     direction
//  req       req_valid, req_stall, opcode .. ff_sign     command word in
//  rsp       rsp_valid, rsp_stall, pwm_out, saturated,   result word out
//            at_rest
//  cfg       cfg_we, cfg_index, cfg_data                 register write in
//
// one 32x24 multiplier and a 1-bit-per-cycle restoring divider are shared
// under the sequencer. loop reset, raw below eps and torque hold skip the
// pi loop; a current or torque step runs it, and deadband compensation
// then runs the divider, also for raw words.
// req_stall is high whenever the sequencer is not idle. the result sits in an
// output register, so the next word is taken while rsp_stall holds a result.
// reset clears the integrator, sets rest and loads register defaults.
module motor_current_pi_drive_core
	import mcpi_pkg::*;
#(
	parameter bit OUTPUT_INVERT = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] command,
	input  logic signed [15:0] measured_current,
	input  logic [15:0]        step_time_us,
	input  logic               use_deadband,
	input  logic signed [1:0]  ff_sign,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [15:0] pwm_out,
	output logic               saturated,
	output logic               at_rest,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	st_t state_q, state_d;

	logic [14:0] duty_limit_q, deadband_q, current_limit_q, torque_eps_q, raw_eps_q;
	logic [31:0] prop_gain_q, integ_gain_q, inv_torque_q;

	op_t                opcode_q;
	logic signed [15:0] cmd_q, meas_q;
	logic [15:0]        dt_q;
	logic               usedb_q;
	logic [1:0]         dir_q;

	logic signed [47:0] integ_q;
	logic               rest_q;

	logic signed [15:0] iref_q;
	logic signed [16:0] err_q;
	logic signed [49:0] pacc_q;
	logic [55:0]        plo_q;
	logic [61:0]        isat_q;
	logic signed [47:0] dfull_q;
	logic signed [15:0] duty_q;
	logic               sat_q;

	logic               sneg_q, t2neg_q, qneg_q;
	logic signed [31:0] t1_q, num_q;
	logic [14:0]        rem_q, dvd_q, quo_q;
	logic [3:0]         cnt_q;

	logic               rsp_valid_q, sat_out_q, rest_out_q;
	logic signed [15:0] pwm_q;

	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic [55:0] mul_p;
	logic [55:0] prod_q;

	// ---- shared combinational terms ----
	logic [16:0] cmd_ext, cmd_mag;
	logic        raw_zero, eps_on, rest_stay, below_eps, hold;
	logic [31:0] k_eff;
	logic [16:0] err_mag;
	logic        err_neg, err_pos;
	logic [47:0] imag;
	logic        dfull_hi, dfull_lo, integ_en;
	logic signed [47:0] mx48;
	logic signed [16:0] m17, duty17, dcl17;
	logic signed [15:0] dcl;
	logic        db_pass, s_neg;
	logic signed [15:0] mdiff;
	logic [14:0] mdiff_mag, duty_mag;
	logic [15:0] div_trial, div_sub;
	logic        div_ge;
	logic [14:0] quo_n;
	logic        out_free;

	function automatic logic signed [15:0] clamp_ref(input logic neg, input logic [31:0] mag,
			input logic [14:0] lim);
		logic [14:0] c;
		c = (mag > {17'd0, lim}) ? lim : mag[14:0];
		return neg ? -$signed({1'b0, c}) : $signed({1'b0, c});
	endfunction

	assign cmd_ext   = {cmd_q[15], cmd_q};
	assign cmd_mag   = cmd_q[15] ? (~cmd_ext + 17'd1) : cmd_ext;
	assign raw_zero  = cmd_mag < {2'b00, raw_eps_q};
	assign eps_on    = torque_eps_q != 15'd0;
	assign rest_stay = {cmd_mag, 1'b0} <= ({3'b000, torque_eps_q} + {2'b00, torque_eps_q, 1'b0});
	assign below_eps = cmd_mag < {2'b00, torque_eps_q};
	assign hold      = eps_on && (rest_q ? rest_stay : below_eps);
	assign k_eff     = (inv_torque_q == 32'd0) ? UNITY_Q16 : inv_torque_q;

	assign err_neg = err_q[16];
	assign err_pos = !err_q[16] && (err_q != 17'sd0);
	assign err_mag = err_neg ? (~err_q + 17'd1) : err_q;
	assign imag    = integ_q[47] ? (~integ_q + 48'd1) : integ_q;

	assign mx48     = $signed({33'd0, duty_limit_q});
	assign dfull_hi = dfull_q > mx48;
	assign dfull_lo = dfull_q < -mx48;
	assign integ_en = (!dfull_hi && !dfull_lo) || (dfull_hi && err_neg) || (dfull_lo && err_pos);

	// duty clamp to +-duty limit
	assign m17    = $signed({2'b00, duty_limit_q});
	assign duty17 = {duty_q[15], duty_q};
	assign dcl17  = (duty17 > m17) ? m17 : ((duty17 < -m17) ? -m17 : duty17);
	assign dcl    = dcl17[15:0];

	assign db_pass = (deadband_q == 15'd0) || (dcl == 16'sd0) || (duty_limit_q == 15'd0);
	always_comb begin
		priority if (dir_q == 2'b01) s_neg = 1'b0;
		else if (dir_q[1])         s_neg = 1'b1;
		else                       s_neg = !(dcl > 16'sd0);
	end

	assign mdiff     = $signed({1'b0, duty_limit_q}) - $signed({1'b0, deadband_q});
	assign mdiff_mag = mdiff[15] ? 15'(-mdiff) : mdiff[14:0];
	assign duty_mag  = duty_q[15] ? 15'(-duty_q) : duty_q[14:0];

	// restoring divider step
	assign div_trial = {rem_q, dvd_q[14]};
	assign div_ge    = div_trial >= {1'b0, duty_limit_q};
	assign div_sub   = div_trial - {1'b0, duty_limit_q};
	assign quo_n     = {quo_q[13:0], div_ge};

	assign out_free = !rsp_valid_q || !rsp_stall;

	assign mul_p = mul_a * mul_b;

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (req_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				unique case (opcode_q)
					OP_RESET:   state_d = ST_IDLE;
					OP_RAW:     state_d = raw_zero ? ST_DRIVE : ST_DB_CHK;
					OP_CURRENT: state_d = ST_CUR;
					OP_TORQUE:  state_d = hold ? ST_DRIVE : ST_TORQ_SCALE;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_TORQ_SCALE: state_d = ST_CUR;
			ST_CUR:        state_d = (iref_q == 16'sd0) ? ST_DRIVE : ST_PMUL;
			ST_PMUL:       state_d = ST_IMUL_LO;
			ST_IMUL_LO:    state_d = ST_IMUL_HI;
			ST_IMUL_HI:    state_d = ST_ISAT;
			ST_ISAT:       state_d = ST_SUM;
			ST_SUM:        state_d = ST_CLAMP;
			ST_CLAMP: begin
				if (integ_en)     state_d = ST_DTMUL;
				else if (usedb_q) state_d = ST_DB_CHK;
				else              state_d = ST_DRIVE;
			end
			ST_DTMUL:      state_d = ST_INTEG;
			ST_INTEG:      state_d = usedb_q ? ST_DB_CHK : ST_DRIVE;
			ST_DB_CHK:     state_d = db_pass ? ST_DRIVE : ST_DB_M2;
			ST_DB_M2:      state_d = ST_DB_M3;
			ST_DB_M3:      state_d = ST_DB_CLAMP;
			ST_DB_CLAMP:   state_d = ST_DIV;
			ST_DIV:        if (cnt_q == 4'd0) state_d = ST_DRIVE;
			ST_DRIVE:      if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// ---- sequencer outputs: stall and multiplier operands ----
	always_comb begin
		req_stall = state_q != ST_IDLE;
		mul_a = 32'd0;
		mul_b = 24'd0;
		unique case (state_q)
			ST_DECODE: begin
				mul_a = k_eff;
				mul_b = {7'd0, cmd_mag};
			end
			ST_PMUL: begin
				mul_a = prop_gain_q;
				mul_b = {7'd0, err_mag};
			end
			ST_IMUL_LO: begin
				mul_a = integ_gain_q;
				mul_b = imag[23:0];
			end
			ST_IMUL_HI: begin
				mul_a = integ_gain_q;
				mul_b = imag[47:24];
			end
			ST_DTMUL: begin
				mul_a = {15'd0, err_mag};
				mul_b = {8'd0, dt_q};
			end
			ST_DB_CHK: begin
				mul_a = {17'd0, deadband_q};
				mul_b = {9'd0, duty_limit_q};
			end
			ST_DB_M2: begin
				mul_a = {17'd0, duty_mag};
				mul_b = {9'd0, mdiff_mag};
			end
			ST_DB_M3: begin
				mul_a = {17'd0, duty_limit_q};
				mul_b = {9'd0, duty_limit_q};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 24'd0;
			end
		endcase
	end

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q    <= DUTY_LIMIT_RST;
			deadband_q      <= 15'd0;
			current_limit_q <= CUR_LIMIT_RST;
			prop_gain_q     <= 32'd0;
			integ_gain_q    <= 32'd0;
			inv_torque_q    <= INV_TORQUE_RST;
			torque_eps_q    <= 15'd0;
			raw_eps_q       <= 15'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DUTY_LIMIT:    duty_limit_q    <= cfg_data[14:0];
				CFG_DEADBAND:      deadband_q      <= cfg_data[14:0];
				CFG_CURRENT_LIMIT: current_limit_q <= cfg_data[14:0];
				CFG_PROP_GAIN:     prop_gain_q     <= cfg_data;
				CFG_INTEG_GAIN:    integ_gain_q    <= cfg_data;
				CFG_INV_TORQUE:    inv_torque_q    <= cfg_data;
				CFG_TORQUE_EPS:    torque_eps_q    <= cfg_data[14:0];
				CFG_RAW_EPS:       raw_eps_q       <= cfg_data[14:0];
				default:           ;
			endcase
		end
	end

	// ---- control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			integ_q     <= 48'sd0;
			rest_q      <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRIVE && out_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall)                 rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_DECODE: begin
					if (opcode_q == OP_RESET) begin
						integ_q <= 48'sd0;
						rest_q  <= 1'b1;
					end else if (opcode_q == OP_TORQUE && eps_on) begin
						if (rest_q && !rest_stay) rest_q <= 1'b0;
						else if (!rest_q && below_eps) rest_q <= 1'b1;
						if (hold) integ_q <= 48'sd0;
					end
				end
				ST_CUR: begin
					if (iref_q == 16'sd0) integ_q <= 48'sd0;
				end
				ST_INTEG: begin : integ_upd
					logic signed [49:0] n;
					logic signed [49:0] d;
					d = $signed({17'd0, prod_q[32:0]});
					n = {{2{integ_q[47]}}, integ_q} + (err_neg ? -d : d);
					// saturate to the 48-bit range
					if (n[49:47] == 3'b000 || n[49:47] == 3'b111) integ_q <= n[47:0];
					else if (n[49])                              integ_q <= {1'b1, 47'd0};
					else                                         integ_q <= {1'b0, {47{1'b1}}};
				end
				default: ;
			endcase
		end
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					opcode_q <= op_t'(opcode);
					cmd_q    <= command;
					meas_q   <= measured_current;
					dt_q     <= (step_time_us == 16'd0) ? DT_DEFAULT : step_time_us;
					usedb_q  <= use_deadband;
					dir_q    <= (op_t'(opcode) == OP_RAW) ? 2'b00 : ff_sign;
				end
			end
			ST_DECODE: begin
				sat_q <= 1'b0;
				if (opcode_q == OP_RAW) duty_q <= raw_zero ? 16'sd0 : cmd_q;
				else if (opcode_q == OP_TORQUE && hold) duty_q <= 16'sd0;
				iref_q <= clamp_ref(cmd_q[15], {15'd0, cmd_mag}, current_limit_q);
			end
			ST_TORQ_SCALE: begin
				iref_q <= clamp_ref(cmd_q[15], prod_q[47:16], current_limit_q);
			end
			ST_CUR: begin
				duty_q <= 16'sd0;
				err_q  <= $signed({iref_q[15], iref_q}) - $signed({meas_q[15], meas_q});
			end
			ST_IMUL_LO: begin : pterm
				logic [49:0] p;
				p = {2'b00, prod_q[47:0]};
				pacc_q <= err_neg ? $signed(~p + 50'd1) : $signed(p);
			end
			ST_IMUL_HI: plo_q <= prod_q;
			ST_ISAT: begin : iterm
				logic [61:0] s;
				s = {1'b0, prod_q[36:0], 24'd0} + {6'd0, plo_q};
				isat_q <= ((|prod_q[55:37]) || (s > PROD_CAP)) ? PROD_CAP : s;
			end
			ST_SUM: begin : pisum
				logic [63:0] iv;
				logic [63:0] tot;
				iv  = {2'b00, isat_q};
				tot = {{14{pacc_q[49]}}, pacc_q} + (integ_q[47] ? (~iv + 64'd1) : iv);
				// arithmetic shift by 16, i.e. floor
				dfull_q <= $signed(tot[63:16]);
			end
			ST_CLAMP: begin
				sat_q <= dfull_hi || dfull_lo;
				if (dfull_hi)      duty_q <= $signed({1'b0, duty_limit_q});
				else if (dfull_lo) duty_q <= -$signed({1'b0, duty_limit_q});
				else               duty_q <= dfull_q[15:0];
			end
			ST_DB_CHK: begin
				duty_q <= dcl;
				sneg_q <= s_neg;
			end
			ST_DB_M2: begin : t1calc
				logic [31:0] p;
				p = {2'b00, prod_q[29:0]};
				t1_q    <= sneg_q ? $signed(~p + 32'd1) : $signed(p);
				t2neg_q <= duty_q[15] ^ mdiff[15];
			end
			ST_DB_M3: begin : numcalc
				logic [31:0] p;
				p = {2'b00, prod_q[29:0]};
				num_q <= t1_q + (t2neg_q ? $signed(~p + 32'd1) : $signed(p));
			end
			ST_DB_CLAMP: begin : numclamp
				logic [31:0] nm;
				logic [29:0] cm;
				nm = num_q[31] ? (~num_q + 32'd1) : num_q;
				cm = (nm > {2'b00, prod_q[29:0]}) ? prod_q[29:0] : nm[29:0];
				// upper half is already below the duty limit
				rem_q  <= cm[29:15];
				dvd_q  <= cm[14:0];
				quo_q  <= 15'd0;
				cnt_q  <= DIV_LAST;
				qneg_q <= num_q[31];
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_sub[14:0] : div_trial[14:0];
				dvd_q <= {dvd_q[13:0], 1'b0};
				quo_q <= quo_n;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0)
					duty_q <= qneg_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
			end
			ST_DRIVE: begin
				if (out_free) begin
					pwm_q      <= OUTPUT_INVERT ? -dcl : dcl;
					sat_out_q  <= sat_q;
					rest_out_q <= rest_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign pwm_out   = pwm_q;
	assign saturated = sat_out_q;
	assign at_rest   = rest_out_q;

endmodule
